// ----- rtl/core/dbsr_pkg.sv -----
// Shared types and constants of the descending bubble sort records block.
`timescale 1ns / 1ps

package dbsr_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int ADDR_W      = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  localparam int TRIP_W  = 16;
  localparam int TAG_W   = 12;
  localparam int FIRST_W = 16;
  localparam int RANK_W  = 6;
  localparam int LIMIT_W = 7;
  localparam int REC_W   = TRIP_W + TAG_W + FIRST_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd10;

  localparam int IN_TDATA_W  = ((REC_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((REC_W + RANK_W + 7) / 8) * 8;

  typedef struct packed {
    logic [FIRST_W-1:0] first;
    logic [TAG_W-1:0]   tag;
    logic [TRIP_W-1:0]  trips;
  } rec_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PSTART,
    ST_PLOAD,
    ST_PASS,
    ST_PEND,
    ST_EM_RD,
    ST_EM_LD
  } state_t;

endpackage

// ----- rtl/core/dbsr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dbsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/descending_bubble_sort_records_core.sv -----
// Top level: record loader, single-comparator bubble sorter and ranked emitter.
`timescale 1ns / 1ps
// in_tready is high while the block is loading. The sort makes passes of span compares,
// one compare per cycle through the one comparator and the RAM's read and write ports, plus
// the states ST_PSTART, ST_PLOAD and ST_PEND per pass. Emitting reads each result from the
// store in ST_EM_RD and loads it into the output register in ST_EM_LD; the read waits until
// the output register is free. rst_n is synchronous and active low; it clears control state,
// empties the store and sets emit_limit to 10; the RAM itself is not cleared.

module descending_bubble_sort_records_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input records.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // in_tdata, lowest bit up: trip_count[15:0], record_tag[11:0], first_count[15:0], zero pad.
  input  logic [dbsr_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               in_tlast,   // last_in
  // Ranked results.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata, lowest bit up: sorted_trips[15:0], sorted_tag[11:0], sorted_first[15:0],
  // rank[5:0], zero pad.
  output logic [dbsr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tuser,  // overflow
  output logic                               out_tlast,  // last_out
  // Configuration: emit_limit.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dbsr_pkg::LIMIT_W-1:0]       cfg_data
);

  import dbsr_pkg::*;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic               dropped_r, dropped_nxt;
  logic [LIMIT_W-1:0] emit_limit_r;
  logic [ADDR_W-1:0]  span_r, span_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  logic               moved_r, moved_nxt;
  rec_t               cur_r, cur_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [ADDR_W-1:0]  e_r, e_nxt;

  logic               out_valid_r, out_valid_nxt;
  rec_t               out_rec_r, out_rec_nxt;
  logic [RANK_W-1:0]  out_rank_r, out_rank_nxt;
  logic               out_ovf_r, out_ovf_nxt;
  logic               out_last_r, out_last_nxt;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [REC_W-1:0]   ram_wdata, ram_rdata;
  rec_t               rd_rec, in_rec;

  logic               in_accept, out_accept;
  logic [CNT_W-1:0]   fill_after;
  logic [LIMIT_W-1:0] lim;
  logic               swap;

  assign in_accept  = in_tvalid && in_tready;
  assign out_accept = out_valid_r && out_tready;
  assign cfg_ready  = 1'b1;

  assign in_rec.trips = in_tdata[TRIP_W-1:0];
  assign in_rec.tag   = in_tdata[TRIP_W+TAG_W-1:TRIP_W];
  assign in_rec.first = in_tdata[REC_W-1:TRIP_W+TAG_W];
  assign rd_rec       = rec_t'(ram_rdata);

  // The only comparator of the sorter: the left neighbor is pushed right when it is
  // strictly smaller, so equal trip counts never swap.
  assign swap = cur_r.trips < rd_rec.trips;

  // A limit of zero means one record.
  assign lim = (emit_limit_r == '0) ? LIMIT_W'(1) : emit_limit_r;

  dbsr_ram #(
    .WIDTH(REC_W),
    .DEPTH(MAX_RECORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      fill_r       <= '0;
      dropped_r    <= 1'b0;
      emit_limit_r <= LIMIT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        emit_limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    span_r     <= span_nxt;
    idx_r      <= idx_nxt;
    moved_r    <= moved_nxt;
    cur_r      <= cur_nxt;
    k_r        <= k_nxt;
    e_r        <= e_nxt;
    out_rec_r  <= out_rec_nxt;
    out_rank_r <= out_rank_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_last_r <= out_last_nxt;
  end

  // Sequencer. A pass keeps the record that is bubbling rightward in cur_r, reads the next
  // entry each cycle and writes back the record that stays behind one place to the left,
  // so the store sees one read and one write per compare at different addresses.
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    dropped_nxt   = dropped_r;
    span_nxt      = span_r;
    idx_nxt       = idx_r;
    moved_nxt     = moved_r;
    cur_nxt       = cur_r;
    k_nxt         = k_r;
    e_nxt         = e_r;
    out_valid_nxt = out_accept ? 1'b0 : out_valid_r;
    out_rec_nxt   = out_rec_r;
    out_rank_nxt  = out_rank_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    fill_after    = fill_r;
    in_tready     = (state_r == ST_LOAD);

    unique case (state_r)
      ST_LOAD: begin
        if (in_accept) begin
          if (fill_r < CNT_W'(MAX_RECORDS)) begin
            ram_we     = 1'b1;
            ram_waddr  = ADDR_W'(fill_r);
            ram_wdata  = in_rec;
            fill_after = fill_r + CNT_W'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          fill_nxt = fill_after;
          if (in_tlast) begin
            k_nxt = (lim > LIMIT_W'(fill_after)) ? fill_after : CNT_W'(lim);
            e_nxt = '0;
            if (fill_after < CNT_W'(2)) begin
              state_nxt = ST_EM_RD;
            end else begin
              span_nxt  = ADDR_W'(fill_after - CNT_W'(1));
              state_nxt = ST_PSTART;
            end
          end
        end
      end
      ST_PSTART: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        moved_nxt = 1'b0;
        state_nxt = ST_PLOAD;
      end
      ST_PLOAD: begin
        cur_nxt   = rd_rec;
        ram_re    = 1'b1;
        ram_raddr = ADDR_W'(1);
        idx_nxt   = ADDR_W'(1);
        state_nxt = ST_PASS;
      end
      ST_PASS: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r - ADDR_W'(1);
        if (swap) begin
          ram_wdata = rd_rec;
          moved_nxt = 1'b1;
        end else begin
          ram_wdata = cur_r;
          cur_nxt   = rd_rec;
        end
        if (idx_r == span_r) begin
          state_nxt = ST_PEND;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_r + ADDR_W'(1);
          idx_nxt   = idx_r + ADDR_W'(1);
        end
      end
      ST_PEND: begin
        ram_we    = 1'b1;
        ram_waddr = span_r;
        ram_wdata = cur_r;
        span_nxt  = span_r - ADDR_W'(1);
        if (moved_r && span_r != ADDR_W'(1)) begin
          state_nxt = ST_PSTART;
        end else begin
          e_nxt     = '0;
          state_nxt = ST_EM_RD;
        end
      end
      ST_EM_RD: begin
        // Read the next rank only once the output register is free by the next edge.
        if (!out_valid_r || out_tready) begin
          ram_re    = 1'b1;
          ram_raddr = e_r;
          state_nxt = ST_EM_LD;
        end
      end
      ST_EM_LD: begin
        out_valid_nxt = 1'b1;
        out_rec_nxt   = rd_rec;
        out_rank_nxt  = RANK_W'(e_r);
        out_ovf_nxt   = dropped_r;
        out_last_nxt  = (CNT_W'(e_r) + CNT_W'(1)) == k_r;
        if ((CNT_W'(e_r) + CNT_W'(1)) == k_r) begin
          fill_nxt    = '0;
          dropped_nxt = 1'b0;
          state_nxt   = ST_LOAD;
        end else begin
          e_nxt     = e_r + ADDR_W'(1);
          state_nxt = ST_EM_RD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - REC_W - RANK_W){1'b0}}, out_rank_r,
                       out_rec_r.first, out_rec_r.tag, out_rec_r.trips};
  assign out_tuser  = out_ovf_r;
  assign out_tlast  = out_last_r;

  // The store never holds more than its capacity.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(MAX_RECORDS))
    else $error("fill count beyond capacity");

  // A compare step always addresses a live pair inside the current pass.
  a_pass_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PASS) |-> (idx_r != '0 && idx_r <= span_r))
    else $error("pass index outside the pass span");

  // A result is loaded only right after its read and never over a waiting result.
  a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EM_LD) |-> ($past(state_r) == ST_EM_RD && !out_valid_r))
    else $error("result loaded over a pending result");

  // The block takes no new record while it sorts or emits.
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOAD) |-> !in_tready)
    else $error("input accepted while busy");

  // The last result of a run carries rank k-1.
  a_last_rank: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EM_LD && (CNT_W'(e_r) + CNT_W'(1)) == k_r) |=>
      (out_tlast && out_rank_r == RANK_W'($past(e_r))))
    else $error("last marker on the wrong rank");

endmodule

// ----- tb/descending_bubble_sort_records_core_tb.sv -----
// Testbench for the descending bubble sort records core: directed and random record sets.
`timescale 1ns / 1ps

module descending_bubble_sort_records_core_tb;
  import dbsr_pkg::*;

  // A run with no request on any channel for this many cycles is hung. The
  // longest quiet stretch is a full 64-record sort.
  localparam int STALL_LIMIT = 20000;
  // Quiet cycles after the last result before the limit register is touched.
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [TRIP_W-1:0]  trips;
    logic [TAG_W-1:0]   tag;
    logic [FIRST_W-1:0] first;
    logic [RANK_W-1:0]  rank;
    logic               overflow;
    logic               last;
  } ranked_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [LIMIT_W-1:0]     cfg_data   = '0;

  // When set, neither side inserts random idle cycles.
  bit steady = 1'b0;
  int error_tally = 0;
  int quiet_cycles = 0;

  // Shadow copy of the block: held records, fill count, drop flag and limit.
  rec_t               held_recs [MAX_RECORDS];
  int                 held_count;
  bit                 held_dropped;
  logic [LIMIT_W-1:0] limit_model;
  ranked_t            pending_ranks [$];

  descending_bubble_sort_records_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Descending bubble sort of the held records; a swap only on strict
  // less-than keeps equal trip counts in arrival order, and a pass without
  // any swap ends the sort.
  task automatic sort_held(input int n);
    int   span;
    bit   moved;
    rec_t tmp;
    if (n < 2) return;
    span = n - 1;
    do begin
      moved = 1'b0;
      for (int i = 0; i < span; i++) begin
        if (held_recs[i].trips < held_recs[i + 1].trips) begin
          moved = 1'b1;
          tmp = held_recs[i];
          held_recs[i] = held_recs[i + 1];
          held_recs[i + 1] = tmp;
        end
      end
      span--;
    end while (moved && span > 0);
  endtask

  // Takes one accepted record; the record marked last sorts the set and
  // queues the top ranks that the block must emit.
  task automatic accept_record(input rec_t r, input bit last);
    int      emit_n;
    ranked_t res;
    if (held_count < MAX_RECORDS) begin
      held_recs[held_count] = r;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (!last) return;
    sort_held(held_count);
    // A limit of zero still emits the top record; a limit above the held
    // count is cut down to what is held.
    emit_n = (limit_model == 0) ? 1 : int'(limit_model);
    if (emit_n > held_count) emit_n = held_count;
    for (int i = 0; i < emit_n; i++) begin
      res.trips    = held_recs[i].trips;
      res.tag      = held_recs[i].tag;
      res.first    = held_recs[i].first;
      res.rank     = RANK_W'(i);
      res.overflow = held_dropped;
      res.last     = (i + 1 == emit_n);
      pending_ranks.push_back(res);
    end
    held_count = 0;
    held_dropped = 1'b0;
  endtask

  // Monitor of the input and configuration channels. Sampling at the rising
  // edge sees the values that were present at the request edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      held_count   = 0;
      held_dropped = 1'b0;
      limit_model  = LIMIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) limit_model = cfg_data;
      if (in_tvalid && in_tready) accept_record(rec_t'(in_tdata[REC_W-1:0]), in_tlast);
    end
  end

  // Result checker: each result request is compared with the oldest expectation.
  always @(posedge clk) begin
    ranked_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_ranks.size() == 0) begin
        $error("unexpected result: tdata %h tuser %b tlast %b", out_tdata, out_tuser, out_tlast);
        error_tally++;
      end else begin
        want = pending_ranks.pop_front();
        if (out_tdata[TRIP_W-1:0] !== want.trips) begin
          $error("sorted_trips: expected %0d, actual %0d", want.trips, out_tdata[TRIP_W-1:0]);
          error_tally++;
        end
        if (out_tdata[TRIP_W +: TAG_W] !== want.tag) begin
          $error("sorted_tag: expected %0d, actual %0d", want.tag, out_tdata[TRIP_W +: TAG_W]);
          error_tally++;
        end
        if (out_tdata[TRIP_W + TAG_W +: FIRST_W] !== want.first) begin
          $error("sorted_first: expected %0d, actual %0d", want.first,
                 out_tdata[TRIP_W + TAG_W +: FIRST_W]);
          error_tally++;
        end
        if (out_tdata[REC_W +: RANK_W] !== want.rank) begin
          $error("rank: expected %0d, actual %0d", want.rank, out_tdata[REC_W +: RANK_W]);
          error_tally++;
        end
        if (out_tuser !== want.overflow) begin
          $error("overflow: expected %0d, actual %0d", want.overflow, out_tuser);
          error_tally++;
        end
        if (out_tlast !== want.last) begin
          $error("last_out: expected %0d, actual %0d", want.last, out_tlast);
          error_tally++;
        end
      end
    end
  end

  // The receiver stalls at random, with a chance of 18 percent, unless steady is set.
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 18);
  end

  // Watchdog on cycles in which no request is taken on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one record. tvalid stays high from one record to the next unless
  // the sender idles; after the record marked last it drops.
  task automatic send_record(input logic [TRIP_W-1:0] trips, input logic [TAG_W-1:0] tag,
                             input logic [FIRST_W-1:0] first, input bit last);
    logic [IN_TDATA_W-1:0] word;
    int                    gap;
    word = '0;
    word[REC_W-1:0] = {first, tag, trips};
    gap = 0;
    while (!steady && $urandom_range(99) < 18) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    if (last) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Holds the sender until every expected result has come, then lets the
  // block settle.
  task automatic drain_results();
    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes emit_limit while the block is idle.
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [TRIP_W-1:0] pick_trips();
    case ($urandom_range(3))
      0:       return TRIP_W'($urandom_range(3));   // many ties
      1:       return $urandom_range(1) ? '1 : '0;
      default: return TRIP_W'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return LIMIT_W'(MAX_RECORDS);
      3:       return LIMIT_W'($urandom_range(127));
      default: return LIMIT_W'($urandom_range(1, 12));
    endcase
  endfunction

  // Default limit of 10 after reset, with the extremes of every field and a
  // run of seven records that arrives in ascending order.
  task automatic test_reset_limit();
    send_record('0, '0, '0, 1'b0);
    send_record('1, '1, '1, 1'b0);
    send_record(16'd1, 12'hAAA, 16'h5555, 1'b0);
    send_record(16'hFFFE, 12'h555, 16'hAAAA, 1'b0);
    for (int i = 0; i < 7; i++) begin
      send_record(TRIP_W'(100 + i * 37), TAG_W'(i + 1), FIRST_W'(i * 1000), 1'b0);
    end
    send_record(16'h8000, 12'h800, 16'h8000, 1'b1);
  endtask

  // A set made of the last record alone, then equal trip counts that must
  // keep their arrival order.
  task automatic test_ties_and_single();
    send_record(16'd4242, 12'd17, 16'd99, 1'b1);
    drain_results();
    send_record(16'd5, 12'd1, 16'd10, 1'b0);
    send_record(16'd9, 12'd2, 16'd20, 1'b0);
    send_record(16'd5, 12'd3, 16'd30, 1'b0);
    send_record(16'd9, 12'd4, 16'd40, 1'b1);
  endtask

  // A zero limit still emits one record; a limit far above the set emits
  // only what is held.
  task automatic test_limit_edges();
    write_limit('0);
    send_record(16'd3, 12'd7, 16'd1, 1'b0);
    send_record(16'd700, 12'd8, 16'd2, 1'b0);
    send_record(16'd30, 12'd9, 16'd3, 1'b1);
    write_limit('1);
    send_record(16'd3, 12'd7, 16'd1, 1'b0);
    send_record(16'd700, 12'd8, 16'd2, 1'b0);
    send_record(16'd30, 12'd9, 16'd3, 1'b1);
  endtask

  // More records than the store holds: the last two, the one marked last
  // among them, are dropped and every result carries the overflow flag.
  task automatic test_overflow();
    write_limit(LIMIT_W'(MAX_RECORDS));
    for (int i = 0; i < MAX_RECORDS + 2; i++) begin
      send_record(pick_trips(), TAG_W'($urandom_range(4095)), FIRST_W'($urandom_range(65535)),
                  i == MAX_RECORDS + 1);
    end
  endtask

  // Random sets, mostly small, with limit changes and pauses between them
  // and a stretch in which neither side idles at random.
  task automatic test_random_sets();
    int sent;
    int size;
    int pick;
    sent = 0;
    while (sent < 90) begin
      pick = $urandom_range(99);
      if (pick < 25) write_limit(pick_limit());
      else if (pick < 40) drain_results();
      size = ($urandom_range(99) < 75) ? $urandom_range(1, 8) : $urandom_range(9, 24);
      for (int i = 0; i < size; i++) begin
        steady = (sent >= 30 && sent < 55);
        send_record(pick_trips(), TAG_W'($urandom_range(4095)), FIRST_W'($urandom_range(65535)),
                    i == size - 1);
        sent++;
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_limit();
    test_ties_and_single();
    test_limit_edges();
    test_overflow();
    test_random_sets();
    drain_results();
    repeat (50) @(posedge clk);
    if (error_tally == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/dbsr_pkg.sv
rtl/core/dbsr_ram.sv
rtl/core/descending_bubble_sort_records_core.sv
tb/descending_bubble_sort_records_core_tb.sv
